FILE: hw/rtl/mlo_pkg.sv
`default_nettype none

package mlo_pkg;

    // Angle pair handed from the front end to the trig back end (yaw Q9.7, pitch Q8.7 degrees)
    typedef struct packed {
        logic signed [15:0] yaw;
        logic signed [14:0] pitch;
    } mlo_angles_t;

    localparam logic [15:0] SENS_RESET = 16'd6554;

    // One full turn in Q9.7 degrees
    localparam int YAW_SPAN = 46080;

    localparam int ATAN_ENTRIES = 24;

    // arctan(2^-i) as a 32-bit binary angle
    function automatic logic [29:0] atan_bam(input logic [4:0] idx);
        logic [29:0] v;
        unique case (idx)
            5'd0:    v = 30'd536870912;
            5'd1:    v = 30'd316933406;
            5'd2:    v = 30'd167458907;
            5'd3:    v = 30'd85004756;
            5'd4:    v = 30'd42667331;
            5'd5:    v = 30'd21354465;
            5'd6:    v = 30'd10679838;
            5'd7:    v = 30'd5340245;
            5'd8:    v = 30'd2670163;
            5'd9:    v = 30'd1335087;
            5'd10:   v = 30'd667544;
            5'd11:   v = 30'd333772;
            5'd12:   v = 30'd166886;
            5'd13:   v = 30'd83443;
            5'd14:   v = 30'd41722;
            5'd15:   v = 30'd20861;
            5'd16:   v = 30'd10430;
            5'd17:   v = 30'd5215;
            5'd18:   v = 30'd2608;
            5'd19:   v = 30'd1304;
            5'd20:   v = 30'd652;
            5'd21:   v = 30'd326;
            5'd22:   v = 30'd163;
            5'd23:   v = 30'd81;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/mlo_front.sv
`default_nettype none

module mlo_front (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [15:0]        sens_i,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [15:0] s_cursor_x,
    input  wire logic signed [15:0] s_cursor_y,
    output logic                    push_o,
    output mlo_pkg::mlo_angles_t    push_data_o,
    input  wire logic               full_i
);
    import mlo_pkg::*;

    localparam int DW = 22;
    // offset that keeps the yaw sum non-negative (12 turns + half turn)
    localparam int YAW_BIAS = 12 * YAW_SPAN + YAW_SPAN / 2;
    localparam int YAW_HALF = YAW_SPAN / 2;
    localparam int PITCH_LIM = 11392;
    // ceil(2^40 / 46080)
    localparam logic [24:0] YAW_RECIP = 25'd23860930;

    typedef enum logic [2:0] {F_IDLE, F_MUL, F_SUM, F_QUOT, F_REM} fstate_t;

    fstate_t                state_reg;
    logic                   first_reg;
    logic signed [15:0]     prev_x_reg, prev_y_reg;
    logic signed [15:0]     yaw_acc_reg;
    logic signed [14:0]     pitch_acc_reg;
    logic signed [16:0]     dx_reg, dy_reg;
    logic signed [DW-1:0]   dyaw_reg, dpitch_reg;
    logic [20:0]            u_reg;
    logic [4:0]             q_reg;

    logic signed [15:0]     base_x, base_y;
    logic signed [16:0]     dx_next, dy_next;
    logic signed [16:0]     sens_s;
    logic signed [33:0]     prod_yaw, prod_pitch;
    logic signed [DW-1:0]   dyaw_next, dpitch_next;
    logic signed [22:0]     u_sum, p_sum;
    logic [20:0]            u_next;
    logic signed [14:0]     pitch_next;
    logic [45:0]            q_prod;
    logic [4:0]             q_next;
    logic [22:0]            rem_u;
    logic signed [16:0]     yaw_wide;
    logic signed [15:0]     yaw_next;

    assign s_ready = (state_reg == F_IDLE);

    // first event: deltas are zero
    assign base_x  = first_reg ? s_cursor_x : prev_x_reg;
    assign base_y  = first_reg ? s_cursor_y : prev_y_reg;
    assign dx_next = 17'(s_cursor_x) - 17'(base_x);
    assign dy_next = 17'(base_y) - 17'(s_cursor_y);

    assign sens_s      = signed'({1'b0, sens_i});
    assign prod_yaw    = dx_reg * sens_s;
    assign prod_pitch  = dy_reg * sens_s;
    assign dyaw_next   = DW'((prod_yaw + 34'sd4096) >>> 13);
    assign dpitch_next = DW'((prod_pitch + 34'sd4096) >>> 13);

    assign u_sum  = 23'(yaw_acc_reg) + 23'(dyaw_reg) + 23'(YAW_BIAS);
    assign u_next = u_sum[20:0];

    assign p_sum = 23'(pitch_acc_reg) + 23'(dpitch_reg);
    always_comb begin
        priority if (p_sum > 23'(PITCH_LIM)) begin
            pitch_next = 15'(PITCH_LIM);
        end else if (p_sum < -23'(PITCH_LIM)) begin
            pitch_next = -15'(PITCH_LIM);
        end else begin
            pitch_next = p_sum[14:0];
        end
    end

    // turns = floor(u / 46080) by reciprocal, exact for u < 32 * 46080 (5-bit result)
    assign q_prod = 46'(u_reg) * 46'(YAW_RECIP);
    assign q_next = q_prod[44:40];

    assign rem_u    = 23'(u_reg) - 23'(q_reg) * 23'(YAW_SPAN);
    assign yaw_wide = signed'(17'(rem_u)) - 17'(YAW_HALF);
    assign yaw_next = yaw_wide[15:0];

    assign push_o            = (state_reg == F_REM) && !full_i;
    assign push_data_o.yaw   = yaw_next;
    assign push_data_o.pitch = pitch_acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= F_IDLE;
            first_reg     <= 1'b1;
            prev_x_reg    <= 16'sd6400;
            prev_y_reg    <= 16'sd4800;
            yaw_acc_reg   <= -16'sd11520;
            pitch_acc_reg <= '0;
        end else begin
            unique case (state_reg)
                F_IDLE: begin
                    if (s_valid) begin
                        dx_reg     <= dx_next;
                        dy_reg     <= dy_next;
                        prev_x_reg <= s_cursor_x;
                        prev_y_reg <= s_cursor_y;
                        first_reg  <= 1'b0;
                        state_reg  <= F_MUL;
                    end
                end
                F_MUL: begin
                    dyaw_reg   <= dyaw_next;
                    dpitch_reg <= dpitch_next;
                    state_reg  <= F_SUM;
                end
                F_SUM: begin
                    u_reg         <= u_next;
                    pitch_acc_reg <= pitch_next;
                    state_reg     <= F_QUOT;
                end
                F_QUOT: begin
                    q_reg     <= q_next;
                    state_reg <= F_REM;
                end
                F_REM: begin
                    if (!full_i) begin
                        yaw_acc_reg <= yaw_next;
                        state_reg   <= F_IDLE;
                    end
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

    a_yaw_range: assert property (@(posedge aclk) disable iff (!aresetn)
        yaw_acc_reg >= -16'(YAW_HALF) && yaw_acc_reg <= 16'(YAW_HALF - 1))
        else $error("yaw accumulator left its wrap range");

    a_turn_exact: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == F_REM |-> rem_u < 23'(YAW_SPAN))
        else $error("yaw turn count off by one");

endmodule

`default_nettype wire

FILE: hw/rtl/mlo_fifo.sv
`default_nettype none

module mlo_fifo #(
    parameter int DEPTH = 2
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push_i,
    input  wire mlo_pkg::mlo_angles_t data_i,
    output logic                      full_o,
    input  wire logic                 pop_i,
    output mlo_pkg::mlo_angles_t      data_o,
    output logic                      empty_o
);
    import mlo_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    mlo_angles_t    mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]  count_reg;

    assign full_o  = (count_reg == CW'(DEPTH));
    assign empty_o = (count_reg == '0);
    assign data_o  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push_i) begin
            mem_reg[wr_ptr_reg] <= data_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push_i) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop_i) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            unique case ({push_i, pop_i})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push_i |-> !full_o)
        else $error("push into full queue");

endmodule

`default_nettype wire

FILE: hw/rtl/mlo_back.sv
`default_nettype none

module mlo_back #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire mlo_pkg::mlo_angles_t pop_data_i,
    input  wire logic                 empty_i,
    output logic                      pop_o,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic signed [15:0]        m_front_x,
    output logic signed [15:0]        m_front_y,
    output logic signed [15:0]        m_front_z,
    output logic signed [15:0]        m_yaw_angle,
    output logic signed [14:0]        m_pitch_angle
);
    import mlo_pkg::*;

    localparam int N_ITER = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
    localparam int IW     = $clog2(N_ITER);

    // deg * 2^32 / 46080 = deg * 2^23 / 90, split as 90*qa + ra
    localparam int          QA_DIV   = 90;
    localparam logic [15:0] QA_RECIP = 16'd46604;          // ceil(2^22 / 90)
    localparam logic [30:0] FR_RECIP = 31'd1527099484;     // ceil(2^37 / 90)
    localparam logic signed [33:0] QUARTER = 34'sd1073741824;
    localparam logic signed [33:0] HALF    = 34'sd2147483648;
    localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
    localparam int UNIT = 16384;

    typedef enum logic [2:0] {B_IDLE, B_QA, B_RA, B_Z, B_ITER, B_MUL, B_OUT} bstate_t;

    bstate_t            state_reg;
    logic [14:0]        mag_reg  [2];
    logic               sgn_reg  [2];
    logic [8:0]         qa_reg   [2];
    logic [22:0]        fr_reg   [2];
    logic signed [33:0] z_reg    [2];
    logic signed [31:0] x_reg    [2];
    logic signed [31:0] y_reg    [2];
    logic               flip_reg [2];
    logic [IW-1:0]      it_reg;
    logic signed [15:0] yaw_hold_reg;
    logic signed [14:0] pitch_hold_reg;
    logic signed [63:0] prod_c_reg, prod_s_reg;
    logic signed [31:0] sp_reg;
    logic               m_valid_reg;
    logic signed [15:0] fx_reg, fy_reg, fz_reg;

    // lane 0 is yaw, lane 1 is pitch
    logic signed [15:0] pop_deg  [2];
    logic [14:0]        mag_next [2];
    logic [30:0]        qa_prod  [2];
    logic [14:0]        ra_w     [2];
    logic [37:0]        fr_prod  [2];
    logic [32:0]        zm       [2];
    logic signed [33:0] zs       [2];
    logic signed [33:0] z_fold   [2];
    logic               flip_next[2];
    logic signed [31:0] x_it     [2];
    logic signed [31:0] y_it     [2];
    logic signed [33:0] z_it     [2];
    logic signed [33:0] at_w;
    logic signed [31:0] cos_yaw, sin_yaw, cos_pitch, sin_pitch;
    logic signed [63:0] rc, rs;
    logic signed [32:0] rp;
    logic               load_out;

    function automatic logic signed [15:0] sat_unit(input logic signed [17:0] v);
        logic signed [15:0] r;
        priority if (v > 18'(UNIT)) begin
            r = 16'(UNIT);
        end else if (v < -18'(UNIT)) begin
            r = -16'(UNIT);
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    assign pop_deg[0] = pop_data_i.yaw;
    assign pop_deg[1] = {pop_data_i.pitch[14], pop_data_i.pitch};
    assign at_w       = signed'(34'(atan_bam(5'(it_reg))));

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            mag_next[l] = pop_deg[l][15] ? 15'(-pop_deg[l]) : 15'(pop_deg[l]);
            qa_prod[l]  = 31'(mag_reg[l]) * 31'(QA_RECIP);
            ra_w[l]     = mag_reg[l] - 15'(qa_reg[l]) * 15'(QA_DIV);
            fr_prod[l]  = 38'(ra_w[l][6:0]) * 38'(FR_RECIP);
            zm[l]       = {1'b0, qa_reg[l], 23'b0} + 33'(fr_reg[l]);
            zs[l]       = sgn_reg[l] ? -signed'({1'b0, zm[l]}) : signed'({1'b0, zm[l]});
            // beyond a quarter turn: rotate by half a turn, negate afterwards
            priority if (zs[l] > QUARTER) begin
                z_fold[l]    = zs[l] - HALF;
                flip_next[l] = 1'b1;
            end else if (zs[l] < -QUARTER) begin
                z_fold[l]    = zs[l] + HALF;
                flip_next[l] = 1'b1;
            end else begin
                z_fold[l]    = zs[l];
                flip_next[l] = 1'b0;
            end
            if (z_reg[l] >= 0) begin
                x_it[l] = x_reg[l] - (y_reg[l] >>> it_reg);
                y_it[l] = y_reg[l] + (x_reg[l] >>> it_reg);
                z_it[l] = z_reg[l] - at_w;
            end else begin
                x_it[l] = x_reg[l] + (y_reg[l] >>> it_reg);
                y_it[l] = y_reg[l] - (x_reg[l] >>> it_reg);
                z_it[l] = z_reg[l] + at_w;
            end
        end
    end

    assign cos_yaw   = flip_reg[0] ? -x_reg[0] : x_reg[0];
    assign sin_yaw   = flip_reg[0] ? -y_reg[0] : y_reg[0];
    assign cos_pitch = flip_reg[1] ? -x_reg[1] : x_reg[1];
    assign sin_pitch = flip_reg[1] ? -y_reg[1] : y_reg[1];

    assign rc = prod_c_reg + 64'sd35184372088832;
    assign rs = prod_s_reg + 64'sd35184372088832;
    assign rp = 33'(sp_reg) + 33'sd32768;

    assign pop_o    = (state_reg == B_IDLE) && !empty_i;
    assign load_out = (state_reg == B_OUT) && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
            it_reg      <= '0;
        end else begin
            if (m_valid_reg && m_ready && !load_out) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE: begin
                    if (!empty_i) begin
                        for (int l = 0; l < 2; l++) begin
                            mag_reg[l] <= mag_next[l];
                            sgn_reg[l] <= pop_deg[l][15];
                        end
                        yaw_hold_reg   <= pop_data_i.yaw;
                        pitch_hold_reg <= pop_data_i.pitch;
                        state_reg      <= B_QA;
                    end
                end
                B_QA: begin
                    for (int l = 0; l < 2; l++) begin
                        qa_reg[l] <= qa_prod[l][30:22];
                    end
                    state_reg <= B_RA;
                end
                B_RA: begin
                    for (int l = 0; l < 2; l++) begin
                        fr_reg[l] <= fr_prod[l][36:14];
                    end
                    state_reg <= B_Z;
                end
                B_Z: begin
                    for (int l = 0; l < 2; l++) begin
                        z_reg[l]    <= z_fold[l];
                        flip_reg[l] <= flip_next[l];
                        x_reg[l]    <= CORDIC_GAIN;
                        y_reg[l]    <= '0;
                    end
                    it_reg    <= '0;
                    state_reg <= B_ITER;
                end
                B_ITER: begin
                    for (int l = 0; l < 2; l++) begin
                        x_reg[l] <= x_it[l];
                        y_reg[l] <= y_it[l];
                        z_reg[l] <= z_it[l];
                    end
                    if (it_reg == IW'(N_ITER - 1)) begin
                        state_reg <= B_MUL;
                    end else begin
                        it_reg <= it_reg + 1'b1;
                    end
                end
                B_MUL: begin
                    prod_c_reg <= cos_yaw * cos_pitch;
                    prod_s_reg <= sin_yaw * cos_pitch;
                    sp_reg     <= sin_pitch;
                    state_reg  <= B_OUT;
                end
                B_OUT: begin
                    if (load_out) begin
                        fx_reg         <= sat_unit(18'(rc >>> 46));
                        fy_reg         <= sat_unit(18'(rp >>> 16));
                        fz_reg         <= sat_unit(18'(rs >>> 46));
                        m_yaw_angle    <= yaw_hold_reg;
                        m_pitch_angle  <= pitch_hold_reg;
                        m_valid_reg    <= 1'b1;
                        state_reg      <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_front_x = fx_reg;
    assign m_front_y = fy_reg;
    assign m_front_z = fz_reg;

    a_digit_split: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == B_RA |-> ra_w[0] < 15'(QA_DIV) && ra_w[1] < 15'(QA_DIV))
        else $error("angle quotient by 90 is off");

    a_folded_angle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == B_ITER && it_reg == '0 |->
            z_reg[0] <= QUARTER && z_reg[0] >= -QUARTER &&
            z_reg[1] <= QUARTER && z_reg[1] >= -QUARTER)
        else $error("CORDIC start angle outside a quarter turn");

    a_unit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> fx_reg <= 16'(UNIT) && fx_reg >= -16'(UNIT) &&
                        fz_reg <= 16'(UNIT) && fz_reg >= -16'(UNIT))
        else $error("forward component beyond unit length");

endmodule

`default_nettype wire

FILE: hw/rtl/mouse_look_orientation.sv
// A request passes the front end, a 2-entry queue and the iterative CORDIC back end to m_valid.
// The back end takes a new entry only when idle and runs min(CORDIC_STAGES,24) micro-rotations,
//   one per cycle with yaw and pitch lanes side by side, so it sets the throughput.
// The front end takes a new request only after pushing the last one into the queue.
// Reset (aresetn low, synchronous): sensitivity 6554, yaw -90 deg, pitch 0,
//   previous cursor (400,300) px, first-event flag set, queue and result register empty.
`default_nettype none

module mouse_look_orientation #(
    parameter int CORDIC_STAGES = 16,
    parameter int QUEUE_DEPTH   = 2
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,

    // sensitivity register write (unsigned Q0.16 degrees per pixel)
    input  wire logic               cfg_wr_en,
    input  wire logic [15:0]        cfg_wr_data,

    // cursor request
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [15:0] s_cursor_x,
    input  wire logic signed [15:0] s_cursor_y,

    // orientation result
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [15:0]      m_front_x,
    output logic signed [15:0]      m_front_y,
    output logic signed [15:0]      m_front_z,
    output logic signed [15:0]      m_yaw_angle,
    output logic signed [14:0]      m_pitch_angle
);
    import mlo_pkg::*;

    logic [15:0]  sens_reg;

    // front end -> queue
    logic         push;
    mlo_angles_t  push_data;
    logic         q_full;

    // queue -> back end
    logic         pop;
    mlo_angles_t  pop_data;
    logic         q_empty;

    // The user must write config only while idle so the front end sees a steady value (not enforced).
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sens_reg <= SENS_RESET;
        end else if (cfg_wr_en) begin
            sens_reg <= cfg_wr_data;
        end
    end

    // Front end: cursor deltas, scaling, yaw wrap and pitch clamp.
    // Holds the angle accumulators and the previous cursor position.
    mlo_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .sens_i      (sens_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cursor_x  (s_cursor_x),
        .s_cursor_y  (s_cursor_y),
        .push_o      (push),
        .push_data_o (push_data),
        .full_i      (q_full)
    );

    // Angle queue: lets the front end run ahead while the CORDIC is busy.
    mlo_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push_i  (push),
        .data_i  (push_data),
        .full_o  (q_full),
        .pop_i   (pop),
        .data_o  (pop_data),
        .empty_o (q_empty)
    );

    // Back end: angle to binary angle conversion, CORDIC sin/cos for both
    // angles, products, rounding and the output register.
    mlo_back #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .pop_data_i    (pop_data),
        .empty_i       (q_empty),
        .pop_o         (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_front_x     (m_front_x),
        .m_front_y     (m_front_y),
        .m_front_z     (m_front_z),
        .m_yaw_angle   (m_yaw_angle),
        .m_pitch_angle (m_pitch_angle)
    );

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`default_nettype none

module tb_top;

    import mlo_pkg::*;

    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_DEPTH    = 24;           // arctangent table depth; later stages are no-ops
    localparam int YAW_HALF      = 23040;        // 180 degrees in Q9.7
    localparam int PITCH_LIMIT   = 11392;        // 89 degrees in Q9.7
    localparam int UNIT_Q14      = 16384;
    localparam longint GAIN_Q30  = 64'sd652032874;
    localparam longint QUARTER   = 64'sd1073741824;   // 90 degrees as a binary angle
    localparam longint HALF_TURN = 64'sd2147483648;   // 180 degrees as a binary angle
    localparam int SETTLE_CYCLES = 40;           // longer than the request latency
    localparam int HOLD_CYCLES   = 600;          // long receiver stall, fills the block
    localparam int CYCLE_LIMIT   = 1000000;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
    } cursor_t;

    typedef struct {
        logic signed [15:0] front_x;
        logic signed [15:0] front_y;
        logic signed [15:0] front_z;
        logic signed [15:0] yaw;
        logic signed [14:0] pitch;
    } orient_t;

    // ---------------------------------------------------------------
    // DUT signals; every input has a known value from time zero
    // ---------------------------------------------------------------
    logic                aclk          = 1'b0;
    logic                aresetn       = 1'b0;
    logic                cfg_wr_en     = 1'b0;
    logic [15:0]         cfg_wr_data   = '0;
    logic                s_valid       = 1'b0;
    logic                s_ready;
    logic signed [15:0]  s_cursor_x    = '0;
    logic signed [15:0]  s_cursor_y    = '0;
    logic                m_valid;
    logic                m_ready       = 1'b0;
    logic signed [15:0]  m_front_x;
    logic signed [15:0]  m_front_y;
    logic signed [15:0]  m_front_z;
    logic signed [15:0]  m_yaw_angle;
    logic signed [14:0]  m_pitch_angle;

    mouse_look_orientation #(
        .CORDIC_STAGES(CORDIC_STAGES)
    ) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cursor_x   (s_cursor_x),
        .s_cursor_y   (s_cursor_y),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_front_x    (m_front_x),
        .m_front_y    (m_front_y),
        .m_front_z    (m_front_z),
        .m_yaw_angle  (m_yaw_angle),
        .m_pitch_angle(m_pitch_angle)
    );

    always #10 aclk = ~aclk;

    // ---------------------------------------------------------------
    // Bookkeeping
    // ---------------------------------------------------------------
    cursor_t cursor_q[$];        // requests waiting for the driver
    orient_t orient_q[$];        // predicted results, oldest first
    int      req_issued   = 0;
    int      res_seen     = 0;
    int      fail_count   = 0;
    int      send_idle_pct = 21;
    int      recv_idle_pct = 71;
    int      hold_asks    = 0;   // bumped by the stimulus to ask for a long stall
    int      hold_served  = 0;
    int      hold_left    = 0;
    int      cycle_count  = 0;

    // random walk position of the stimulus generator
    logic signed [15:0] roam_x = '0;
    logic signed [15:0] roam_y = '0;

    // ---------------------------------------------------------------
    // Camera model: own copy of the register and the accumulators
    // ---------------------------------------------------------------
    int sens_now;
    bit first_evt;
    int last_x, last_y;
    int yaw_deg, pitch_deg;

    function automatic longint arctan_step(input int i);
        case (i)
            0:  return 536870912;
            1:  return 316933406;
            2:  return 167458907;
            3:  return 85004756;
            4:  return 42667331;
            5:  return 21354465;
            6:  return 10679838;
            7:  return 5340245;
            8:  return 2670163;
            9:  return 1335087;
            10: return 667544;
            11: return 333772;
            12: return 166886;
            13: return 83443;
            14: return 41722;
            15: return 20861;
            16: return 10430;
            17: return 5215;
            18: return 2608;
            19: return 1304;
            20: return 652;
            21: return 326;
            22: return 163;
            23: return 81;
            default: return 0;
        endcase
    endfunction

    // add half an LSB, then floor-shift
    function automatic longint round_shift(input longint v, input int sh);
        return (v + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint clamp_unit(input longint v);
        if (v > UNIT_Q14) return UNIT_Q14;
        if (v < -UNIT_Q14) return -UNIT_Q14;
        return v;
    endfunction

    // cos/sin in Q2.30 of a Q9.7 degree angle in [-180,180)
    function automatic void angle_sincos(input int deg, output longint c, output longint s);
        longint z, x, y, nx;
        bit     flip;
        z = (longint'(deg) <<< 32) / YAW_SPAN;   // truncates toward zero
        x = GAIN_Q30;
        y = 0;
        flip = 1'b0;
        // outside +/-90 degrees: rotate by half a turn and negate at the end
        if (z > QUARTER) begin
            z = z - HALF_TURN;
            flip = 1'b1;
        end else if (z < -QUARTER) begin
            z = z + HALF_TURN;
            flip = 1'b1;
        end
        for (int i = 0; i < CORDIC_STAGES && i < ATAN_DEPTH; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - arctan_step(i);
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + arctan_step(i);
            end
            x = nx;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = x;
        s = y;
    endfunction

    // Advance the camera by one cursor request and return the expected result
    function automatic orient_t predict_orientation(input logic signed [15:0] cx,
                                                    input logic signed [15:0] cy);
        longint  dx, dy, acc, cyw, syw, cp, sp;
        orient_t r;
        // first request only records where the cursor is
        if (first_evt) begin
            last_x = cx;
            last_y = cy;
            first_evt = 1'b0;
        end
        dx = longint'(cx) - last_x;
        dy = longint'(last_y) - longint'(cy);   // screen y grows downward
        last_x = cx;
        last_y = cy;

        // yaw wraps into [-180,180) however far it moved
        acc = longint'(yaw_deg) + YAW_HALF + round_shift(dx * longint'(sens_now), 13);
        acc = acc % YAW_SPAN;
        if (acc < 0) acc = acc + YAW_SPAN;
        yaw_deg = int'(acc - YAW_HALF);

        // pitch saturates at +/-89 degrees
        acc = longint'(pitch_deg) + round_shift(dy * longint'(sens_now), 13);
        if (acc > PITCH_LIMIT) acc = PITCH_LIMIT;
        if (acc < -PITCH_LIMIT) acc = -PITCH_LIMIT;
        pitch_deg = int'(acc);

        angle_sincos(yaw_deg, cyw, syw);
        angle_sincos(pitch_deg, cp, sp);

        r.front_x = 16'(clamp_unit(round_shift(cyw * cp, 46)));
        r.front_y = 16'(clamp_unit(round_shift(sp, 16)));
        r.front_z = 16'(clamp_unit(round_shift(syw * cp, 46)));
        r.yaw     = 16'(yaw_deg);
        r.pitch   = 15'(pitch_deg);
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Driver: offers queued requests, predicts at acceptance
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            s_cursor_x <= '0;
            s_cursor_y <= '0;
        end else begin
            if (s_valid && s_ready) begin
                orient_q.push_back(predict_orientation(s_cursor_x, s_cursor_y));
            end
            // the slot is free after this edge; valid is never dropped while waiting
            if (!s_valid || s_ready) begin
                if (cursor_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid    <= 1'b1;
                    s_cursor_x <= cursor_q[0].x;
                    s_cursor_y <= cursor_q[0].y;
                    void'(cursor_q.pop_front());
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: takes results, compares against the oldest prediction
    // ---------------------------------------------------------------
    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        orient_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                res_seen++;
                if (orient_q.size() == 0) begin
                    $error("result with no request outstanding");
                    fail_count++;
                end else begin
                    want = orient_q.pop_front();
                    check_field("front_x", int'(want.front_x), int'(m_front_x));
                    check_field("front_y", int'(want.front_y), int'(m_front_y));
                    check_field("front_z", int'(want.front_z), int'(m_front_z));
                    check_field("yaw_angle", int'(want.yaw), int'(m_yaw_angle));
                    check_field("pitch_angle", int'(want.pitch), int'(m_pitch_angle));
                end
            end
            // long stall on request; the sender keeps offering meanwhile
            if (hold_asks != hold_served) begin
                hold_served <= hold_asks;
                hold_left   <= HOLD_CYCLES;
                m_ready     <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[mouse_look_orientation] ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    task automatic push_cursor(input int x, input int y);
        cursor_t c;
        c.x = 16'(x);
        c.y = 16'(y);
        cursor_q.push_back(c);
        req_issued++;
    endtask

    // wait until every request has come back
    task automatic drain();
        do @(negedge aclk); while (res_seen < req_issued);
    endtask

    // only called with the block idle
    task automatic write_sensitivity(input logic [15:0] v);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sens_now = v;
        @(negedge aclk);
    endtask

    // With sensitivity 8192 a Q12.4 delta maps 1:1 onto Q9.7 degrees, so two
    // requests (recenter, then move) land both angles exactly on a target.
    task automatic steer_angles(input int yaw_t, input int pitch_t);
        int dyaw, dpitch;
        push_cursor(0, 0);
        drain();
        dyaw = yaw_t - yaw_deg;
        if (dyaw >= YAW_HALF) dyaw = dyaw - YAW_SPAN;
        else if (dyaw < -YAW_HALF) dyaw = dyaw + YAW_SPAN;
        dpitch = pitch_t - pitch_deg;
        push_cursor(dyaw, -dpitch);
        drain();
    endtask

    // Mostly a random walk of the cursor (small to medium steps), some repeats
    // of the same spot and some jumps anywhere in the 16-bit range.
    task automatic queue_random_moves(input int count);
        int pick, step;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                step = 1 << $urandom_range(12);
                roam_x = roam_x + 16'(int'($urandom_range(2 * step)) - step);
                step = 1 << $urandom_range(12);
                roam_y = roam_y + 16'(int'($urandom_range(2 * step)) - step);
            end else if (pick >= 80) begin
                roam_x = 16'($urandom);
                roam_y = 16'($urandom);
            end
            push_cursor(roam_x, roam_y);
        end
    endtask

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial begin
        // model state after reset
        sens_now  = SENS_RESET;
        first_evt = 1'b1;
        last_x    = 6400;
        last_y    = 4800;
        yaw_deg   = -11520;
        pitch_deg = 0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // sender idles a little, receiver a lot; reset sensitivity
        send_idle_pct = 21;
        recv_idle_pct = 71;
        push_cursor(100, -200);          // first request: position only recorded
        push_cursor(100, -200);          // no motion
        push_cursor(32767, -32768);      // extreme positions, big deltas both ways
        push_cursor(-32768, 32767);
        push_cursor(-32768, -32768);
        push_cursor(32767, 32767);
        push_cursor(0, 0);
        push_cursor(1, -1);              // one LSB of motion
        drain();
        hold_asks++;                     // long stall while the walk streams in
        queue_random_moves(240);
        drain();

        // unity mapping: hit angle edges exactly
        write_sensitivity(16'd8192);
        steer_angles(-YAW_HALF, PITCH_LIMIT);       // yaw -180, pitch at +89
        steer_angles(YAW_HALF - 1, -PITCH_LIMIT);   // yaw just below +180, pitch at -89
        steer_angles(11520, 0);                     // exactly +90, no half-turn fold
        steer_angles(11521, 5000);                  // just past +90, folded
        steer_angles(-11520, -1);
        steer_angles(-11521, 0);
        queue_random_moves(200);
        drain();

        // now the receiver is the quick side
        send_idle_pct = 71;
        recv_idle_pct = 21;
        write_sensitivity(16'hFFFF);     // largest sensitivity: yaw wraps, pitch pins
        queue_random_moves(200);
        drain();
        write_sensitivity(16'd0);        // angles frozen whatever the cursor does
        queue_random_moves(80);
        drain();

        // no idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_sensitivity(16'd1);
        queue_random_moves(60);
        drain();
        write_sensitivity(16'($urandom_range(65535)));
        hold_asks++;
        queue_random_moves(250);
        drain();

        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (fail_count == 0 && orient_q.size() == 0) begin
            $display("[mouse_look_orientation] OK");
        end else begin
            $display("[mouse_look_orientation] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
